[design/ehcr_pkg.sv]
// Shared types, constants and helpers for the Ethernet II header classifier.
package ehcr_pkg;

    localparam int MacW       = 48;
    localparam int ByteW      = 8;
    localparam int TypeW      = 16;
    localparam int IdxW       = 4;
    localparam int QueueDepth = 4;
    localparam int QPtrW      = $clog2(QueueDepth);
    localparam int QCntW      = $clog2(QueueDepth + 1);

    localparam logic [MacW-1:0]  BcastMac  = '1;
    localparam logic [TypeW-1:0] TypeArp   = 16'h0806;
    localparam logic [TypeW-1:0] TypeIpv4  = 16'h0800;

    // Header byte positions
    localparam logic [IdxW-1:0] PosSrcFirst = 4'd6;
    localparam logic [IdxW-1:0] PosTypeHi   = 4'd12;
    localparam logic [IdxW-1:0] PosTypeLo   = 4'd13;
    localparam logic [IdxW-1:0] PosPastHdr  = 4'd14;

    // Reply sequencer steps
    localparam logic [IdxW-1:0] StepLocalFirst = 4'd6;
    localparam logic [IdxW-1:0] StepTypeHi     = 4'd12;
    localparam logic [IdxW-1:0] StepTypeLo     = 4'd13;
    localparam logic [IdxW-1:0] StepVerdict    = 4'd14;

    typedef enum logic [1:0] {
        VERDICT_DROP = 2'd0,
        VERDICT_ARP  = 2'd1,
        VERDICT_IP   = 2'd2
    } t_verdict;

    typedef enum logic {
        KIND_VERDICT = 1'b0,
        KIND_REPLY   = 1'b1
    } t_kind;

    // One classified frame handed from front to back
    typedef struct packed {
        logic              reply;
        t_verdict          verdict;
        logic [MacW-1:0]   src_mac;
        logic [TypeW-1:0]  etype;
    } t_cmd;

    // Pick byte i (0 = first on the wire) of a MAC address
    function automatic logic [ByteW-1:0] mac_byte(input logic [MacW-1:0] mac,
                                                  input logic [2:0] i);
        logic [ByteW-1:0] b;
        unique case (i)
            3'd0:    b = mac[47:40];
            3'd1:    b = mac[39:32];
            3'd2:    b = mac[31:24];
            3'd3:    b = mac[23:16];
            3'd4:    b = mac[15:8];
            3'd5:    b = mac[7:0];
            default: b = '0;
        endcase
        return b;
    endfunction

endpackage

[design/ehcr_front.sv]
// Front end: captures header bytes and classifies each frame on its last header byte.
module ehcr_front import ehcr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [ByteW-1:0]  i_rx_byte,
    input  logic              i_frame_start,
    input  logic [MacW-1:0]   i_local_mac,
    output logic              o_cmd_push,
    output t_cmd              o_cmd
);

    logic [IdxW-1:0]  r_byte_index, n_byte_index;
    logic [MacW-1:0]  r_dest_mac;
    logic [MacW-1:0]  r_src_mac;
    logic [ByteW-1:0] r_type_hi;
    logic [IdxW-1:0]  pos;
    logic [TypeW-1:0] etype;
    logic             addr_ok;

    // Restart position on a frame start, hold once past the header
    always_comb begin
        pos          = i_frame_start ? '0 : r_byte_index;
        n_byte_index = (pos < PosPastHdr) ? pos + 4'd1 : pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= '0;
        end else if (i_accept) begin
            r_byte_index <= n_byte_index;
        end
    end

    // Capture header fields
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            if (pos < PosSrcFirst) begin
                r_dest_mac <= {r_dest_mac[MacW-ByteW-1:0], i_rx_byte};
            end else if (pos < PosTypeHi) begin
                r_src_mac <= {r_src_mac[MacW-ByteW-1:0], i_rx_byte};
            end else if (pos == PosTypeHi) begin
                r_type_hi <= i_rx_byte;
            end
        end
    end

    // Classify on the second EtherType byte
    always_comb begin
        etype           = {r_type_hi, i_rx_byte};
        addr_ok         = (r_dest_mac == i_local_mac) || (r_dest_mac == BcastMac);
        o_cmd_push      = i_accept && (pos == PosTypeLo);
        o_cmd.src_mac   = r_src_mac;
        o_cmd.etype     = etype;
        o_cmd.reply     = 1'b0;
        o_cmd.verdict   = VERDICT_DROP;
        if (etype == TypeArp) begin
            o_cmd.verdict = VERDICT_ARP;
        end else if (etype == TypeIpv4 && addr_ok) begin
            o_cmd.verdict = VERDICT_IP;
            o_cmd.reply   = 1'b1;
        end
    end

endmodule

[design/ehcr_queue.sv]
// Short command queue between the classifying front and the emitting back.
module ehcr_queue import ehcr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_cmd  i_cmd,
    input  logic  i_pop,
    output t_cmd  o_head,
    output logic  o_valid,
    output logic  o_full
);

    t_cmd               r_mem [QueueDepth];
    logic [QPtrW-1:0]   r_wr_ptr;
    logic [QPtrW-1:0]   r_rd_ptr;
    logic [QCntW-1:0]   r_count;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == QCntW'(QueueDepth));

    // Store incoming request
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push || i_pop)
        else $error("queue pushed while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop)
        else $error("queue popped while empty");

endmodule

[design/ehcr_back.sv]
// Back end: turns each queued command into verdict and reply-header results.
module ehcr_back import ehcr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic              i_cmd_valid,
    input  logic [MacW-1:0]   i_local_mac,
    input  logic              i_pop,
    output logic              o_cmd_pop,
    output logic              o_empty,
    output logic              o_kind,
    output logic [1:0]        o_verdict,
    output logic [ByteW-1:0]  o_tx_byte,
    output logic              o_last
);

    logic [IdxW-1:0]  r_step;
    logic             r_out_valid;
    logic             r_kind;
    t_verdict         r_verdict;
    logic [ByteW-1:0] r_tx_byte;
    logic             r_last;

    logic             advance;
    logic             n_kind;
    t_verdict         n_verdict;
    logic [ByteW-1:0] n_tx_byte;
    logic             n_last;
    logic [IdxW-1:0]  local_idx;

    // Load the output register whenever it is free or being taken
    assign advance   = i_cmd_valid && (!r_out_valid || i_pop);
    assign local_idx = r_step - StepLocalFirst;

    // Build the next result from the head command and step
    always_comb begin
        n_kind    = KIND_VERDICT;
        n_verdict = i_cmd.verdict;
        n_tx_byte = '0;
        n_last    = 1'b1;
        if (i_cmd.reply) begin
            n_kind = KIND_REPLY;
            n_last = 1'b0;
            n_verdict = VERDICT_DROP;
            if (r_step < StepLocalFirst) begin
                n_tx_byte = mac_byte(i_cmd.src_mac, r_step[2:0]);
            end else if (r_step < StepTypeHi) begin
                n_tx_byte = mac_byte(i_local_mac, local_idx[2:0]);
            end else if (r_step == StepTypeHi) begin
                n_tx_byte = i_cmd.etype[15:8];
            end else if (r_step == StepTypeLo) begin
                n_tx_byte = i_cmd.etype[7:0];
            end else begin
                n_kind    = KIND_VERDICT;
                n_verdict = VERDICT_IP;
                n_last    = 1'b1;
            end
        end
        o_cmd_pop = advance && (!i_cmd.reply || r_step == StepVerdict);
    end

    // Step through the reply sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (o_cmd_pop) begin
            r_step <= '0;
        end else if (advance) begin
            r_step <= r_step + 4'd1;
        end
    end

    // Hold the result until it is popped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_kind    <= n_kind;
            r_verdict <= n_verdict;
            r_tx_byte <= n_tx_byte;
            r_last    <= n_last;
        end
    end

    assign o_empty   = !r_out_valid;
    assign o_kind    = r_kind;
    assign o_verdict = r_verdict;
    assign o_tx_byte = r_tx_byte;
    assign o_last    = r_last;

    a_step_needs_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != '0) |-> i_cmd_valid && i_cmd.reply)
        else $error("reply step active without a reply command");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= StepVerdict)
        else $error("reply step out of range");

    a_reply_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == KIND_REPLY) |-> !r_last)
        else $error("reply header byte marked last");

endmodule

[design/eth_header_classify_and_reply_top.sv]
// Top level of the Ethernet II header classifier with reply-header generation.
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+--------------------------------------
//  input    | push / full           | i_rx_byte, i_frame_start
//  result   | empty / pop           | o_kind, o_verdict, o_tx_byte, o_last
//  config   | i_cfg_we              | i_cfg_wdata (local MAC)
//
//  One received byte is taken per cycle while full is low; full rises only
//  when the four-entry command queue between front and back is full.
//  Results leave one per cycle while pop is held: one for a drop or ARP
//  frame, fifteen for an accepted IPv4 frame, set by the back-end step
//  counter. Each result loads from the queue head into the output register
//  when that register is empty or being popped. Reset (synchronous, active
//  low) clears the byte position, queue and output register; local MAC resets to zero.
module eth_header_classify_and_reply_top import ehcr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [ByteW-1:0]  i_rx_byte,
    input  logic              i_frame_start,
    output logic              empty,
    input  logic              pop,
    output logic              o_kind,
    output logic [1:0]        o_verdict,
    output logic [ByteW-1:0]  o_tx_byte,
    output logic              o_last,
    input  logic              i_cfg_we,
    input  logic [MacW-1:0]   i_cfg_wdata
);

    logic [MacW-1:0] r_local_mac;
    logic            accept;
    logic            cmd_push;
    logic            cmd_pop;
    logic            cmd_valid;
    t_cmd            cmd_in;
    t_cmd            cmd_head;

    // Hold the station address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_mac <= '0;
        end else if (i_cfg_we) begin
            r_local_mac <= i_cfg_wdata;
        end
    end

    assign accept = push && !full;

    ehcr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_rx_byte     (i_rx_byte),
        .i_frame_start (i_frame_start),
        .i_local_mac   (r_local_mac),
        .o_cmd_push    (cmd_push),
        .o_cmd         (cmd_in)
    );

    ehcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .i_pop   (cmd_pop),
        .o_head  (cmd_head),
        .o_valid (cmd_valid),
        .o_full  (full)
    );

    ehcr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_head),
        .i_cmd_valid (cmd_valid),
        .i_local_mac (r_local_mac),
        .i_pop       (pop),
        .o_cmd_pop   (cmd_pop),
        .o_empty     (empty),
        .o_kind      (o_kind),
        .o_verdict   (o_verdict),
        .o_tx_byte   (o_tx_byte),
        .o_last      (o_last)
    );

endmodule
